[sv/tccs_pkg.sv]
`timescale 1ns / 1ps

package tccs_pkg;

   // Field widths of the request and response transfers
   localparam int CMD_W  = 1;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

   // Character and attribute codes
   localparam logic [CHAR_W-1:0] SPACE_CODE      = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'h0A;
   localparam logic [CHAR_W-1:0] FIXED_ATTRIBUTE = 8'h0F;

   typedef logic [CHAR_W-1:0] char_type;

endpackage

[sv/text_console_cursor_scroll_unit.sv]
`timescale 1ns / 1ps

// Channel   | Ports                                          | Transfer when
// ----------+------------------------------------------------+---------------------------
// request   | start, busy, req_command, req_char_code,       | start high and busy low
//           | req_read_row, req_read_column                  |
// response  | rsp_strobe, rsp_cell_char, rsp_cell_attribute, | every cycle rsp_strobe high
//           | rsp_cursor_row, rsp_cursor_column, rsp_scrolled|
//
// A put or read first accesses the character memory, then registers the
// response; the response shows while the next request is taken.
// A put that scrolls walks the whole memory once through its one read port
// and one write port, one cell a cycle.
// After reset the memory is cleared to spaces, one cell a cycle; busy stays
// high until that pass is done.
// The receiver cannot stall: each response holds for exactly one cycle.
module text_console_cursor_scroll_unit
   import tccs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ROW_W-1:0]  req_read_row,
   input  logic [COL_W-1:0]  req_read_column,
   output logic              rsp_strobe,
   output logic [CHAR_W-1:0] rsp_cell_char,
   output logic [CHAR_W-1:0] rsp_cell_attribute,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [COL_W-1:0]  rsp_cursor_column,
   output logic              rsp_scrolled
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(CELLS + 1);
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = $clog2(COLUMNS);
   localparam int COPY_END = CELLS - COLUMNS;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_SCROLL = 2'd3;

   // Control and cursor state
   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          hit_ff, hit_in;
   logic          rd_cmd_ff, rd_cmd_in;

   // Copy stage of the sweep
   logic          copy_vld_ff, copy_vld_in;
   logic [AW-1:0] copy_adr_ff, copy_adr_in;
   logic          copy_fill_ff, copy_fill_in;

   // Response registers
   logic          strobe_ff, strobe_in;
   char_type      cell_ff, cell_in;
   logic          scrolled_ff, scrolled_in;

   // Memory ports
   char_type      mem [CELLS];
   char_type      rdata_ff;
   logic          rd_en;
   logic [AW-1:0] rd_adr;
   logic          wr_en;
   logic [AW-1:0] wr_adr;
   char_type      wr_data;

   logic          accept;
   logic          is_put;
   logic          is_newline;
   logic [RW:0]   row_inc;
   logic [CW:0]   col_inc;
   logic          read_hit;
   logic [AW-1:0] cursor_adr;
   logic [AW-1:0] read_adr;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign is_put = (req_command == CMD_PUT);
   assign is_newline = (req_char_code == NEWLINE_CODE);
   assign row_inc = {1'b0, row_ff} + 1'b1;
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign read_hit = (32'(req_read_row) < ROWS) && (32'(req_read_column) < COLUMNS);
   assign cursor_adr = AW'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign read_adr = AW'(32'(req_read_row) * COLUMNS + 32'(req_read_column));

   // Sequence the clear pass, item access and scroll sweep
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      hit_in       = hit_ff;
      rd_cmd_in    = rd_cmd_ff;
      copy_vld_in  = 1'b0;
      copy_adr_in  = copy_adr_ff;
      copy_fill_in = copy_fill_ff;
      strobe_in    = 1'b0;
      cell_in      = cell_ff;
      scrolled_in  = scrolled_ff;
      rd_en        = 1'b0;
      rd_adr       = read_adr;
      wr_en        = 1'b0;
      wr_adr       = cursor_adr;
      wr_data      = req_char_code;

      unique case (state_ff) inside
         ST_CLEAR, ST_SCROLL: begin
            if (sweep_ff < SW'(CELLS)) begin
               copy_vld_in  = 1'b1;
               copy_adr_in  = sweep_ff[AW-1:0];
               copy_fill_in = (state_ff == ST_CLEAR) || (sweep_ff >= SW'(COPY_END));
               rd_en        = !copy_fill_in;
               rd_adr       = AW'(32'(sweep_ff) + COLUMNS);
               sweep_in     = sweep_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
               if (state_ff == ST_SCROLL) begin
                  strobe_in   = 1'b1;
                  cell_in     = '0;
                  scrolled_in = 1'b1;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_cmd_in = !is_put;
               hit_in    = read_hit;
               state_in  = ST_WAIT;
               if (is_put) begin
                  // store the byte unless it is a newline, then advance the cursor
                  wr_en = !is_newline;
                  if (is_newline || (32'(col_inc) >= COLUMNS)) begin
                     col_in = '0;
                     if (32'(row_inc) >= ROWS) begin
                        row_in   = RW'(ROWS - 1);
                        sweep_in = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in = row_inc[RW-1:0];
                     end
                  end else begin
                     col_in = col_inc[CW-1:0];
                  end
               end else begin
                  rd_en = read_hit;
               end
            end
         end
         ST_WAIT: begin
            state_in    = ST_IDLE;
            strobe_in   = 1'b1;
            scrolled_in = 1'b0;
            cell_in     = (rd_cmd_ff && hit_ff) ? rdata_ff : '0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write back the copy stage of the sweep
      if (copy_vld_ff) begin
         wr_en   = 1'b1;
         wr_adr  = copy_adr_ff;
         wr_data = copy_fill_ff ? SPACE_CODE : rdata_ff;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         sweep_ff    <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         copy_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         copy_vld_ff <= copy_vld_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      rd_cmd_ff    <= rd_cmd_in;
      copy_adr_ff  <= copy_adr_in;
      copy_fill_ff <= copy_fill_in;
      cell_ff      <= cell_in;
      scrolled_ff  <= scrolled_in;
   end

   // Character memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_adr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_adr];
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_cell_char      = cell_ff;
   assign rsp_cell_attribute = FIXED_ATTRIBUTE;
   assign rsp_cursor_row     = ROW_W'(row_ff);
   assign rsp_cursor_column  = COL_W'(col_ff);
   assign rsp_scrolled       = scrolled_ff;

`ifndef SYNTH
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == ST_IDLE))
      else $error("response transfer outside idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request transfer");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS))
      else $error("cursor outside grid");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && scrolled_ff) |-> ((32'(row_ff) == ROWS - 1) && (col_ff == '0)))
      else $error("cursor not at bottom row start after scroll");

   a_no_put_in_sweep: assert property (@(posedge clock) disable iff (reset)
      copy_vld_ff |-> !accept)
      else $error("request transfer during sweep");
`endif

endmodule
